/* rtl/mngp_pkg.sv */
`default_nettype none
package mngp_pkg;

	// byte decode
	localparam logic [7:0] STATUS_MASK = 8'h80;
	localparam logic [7:0] KIND_MASK   = 8'hF0;
	localparam logic [7:0] KIND_NOTE_OFF = 8'h80;
	localparam logic [7:0] KIND_NOTE_ON  = 8'h90;

	// pitch memory geometry
	localparam int NOTE_W  = 7;
	localparam int STEP_W  = 16;
	localparam int NOTES   = 128;
	localparam int FILL_W  = NOTE_W + 1;

	// phase increment for each midi note
	localparam logic [STEP_W-1:0] PITCH_TABLE [0:NOTES-1] = '{
		16'd32,    16'd34,    16'd36,    16'd39,    16'd41,    16'd43,    16'd46,    16'd49,
		16'd52,    16'd55,    16'd58,    16'd62,    16'd65,    16'd69,    16'd73,    16'd78,
		16'd82,    16'd87,    16'd92,    16'd98,    16'd104,   16'd110,   16'd117,   16'd124,
		16'd131,   16'd139,   16'd147,   16'd156,   16'd165,   16'd175,   16'd185,   16'd197,
		16'd208,   16'd221,   16'd234,   16'd248,   16'd263,   16'd278,   16'd295,   16'd312,
		16'd331,   16'd351,   16'd371,   16'd394,   16'd417,   16'd442,   16'd468,   16'd496,
		16'd526,   16'd557,   16'd590,   16'd625,   16'd662,   16'd702,   16'd743,   16'd788,
		16'd835,   16'd884,   16'd937,   16'd993,   16'd1052,  16'd1114,  16'd1180,  16'd1251,
		16'd1325,  16'd1404,  16'd1487,  16'd1576,  16'd1670,  16'd1769,  16'd1874,  16'd1986,
		16'd2104,  16'd2229,  16'd2361,  16'd2502,  16'd2651,  16'd2808,  16'd2975,  16'd3152,
		16'd3340,  16'd3538,  16'd3749,  16'd3972,  16'd4208,  16'd4458,  16'd4723,  16'd5004,
		16'd5302,  16'd5617,  16'd5951,  16'd6305,  16'd6680,  16'd7077,  16'd7498,  16'd7944,
		16'd8417,  16'd8917,  16'd9447,  16'd10009, 16'd10604, 16'd11235, 16'd11903, 16'd12611,
		16'd13361, 16'd14155, 16'd14997, 16'd15889, 16'd16834, 16'd17835, 16'd18895, 16'd20019,
		16'd21209, 16'd22470, 16'd23807, 16'd25222, 16'd26722, 16'd28311, 16'd29995, 16'd31778,
		16'd33668, 16'd35670, 16'd37791, 16'd40038, 16'd42419, 16'd44941, 16'd47614, 16'd50445
	};

	// per-item info handed from the decode stage to the output stage
	typedef struct packed {
		logic              gate;
		logic [NOTE_W-1:0] note;
		logic              struck;
	} s1_info_t;

endpackage
`default_nettype wire

/* rtl/mngp_if.sv */
`default_nettype none
// received byte channel
interface mngp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// note state channel
interface mngp_note_if;
	logic        valid;
	logic        ready;
	logic        gate;
	logic [15:0] phase_step;
	logic [6:0]  held_note;
	logic        key_struck;

	modport source (output valid, output gate, output phase_step, output held_note,
		output key_struck, input ready);
	modport sink   (input valid, input gate, input phase_step, input held_note,
		input key_struck, output ready);
endinterface
`default_nettype wire

/* rtl/mngp_ram.sv */
`default_nettype none
module mngp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/mngp_parse.sv */
`default_nettype none
module mngp_parse (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [7:0]                    rx_byte,
	output logic      [mngp_pkg::NOTE_W-1:0]   rd_addr,
	output mngp_pkg::s1_info_t                 info_s1
);

	logic [7:0]                  status_q;
	logic                        count_q;
	logic [mngp_pkg::NOTE_W-1:0] first_q;
	logic                        gate_q;
	logic [mngp_pkg::NOTE_W-1:0] note_q;

	logic [7:0]                  status_n;
	logic                        count_n;
	logic [mngp_pkg::NOTE_W-1:0] first_n;
	logic                        gate_n;
	logic [mngp_pkg::NOTE_W-1:0] note_n;
	logic                        struck;
	logic [7:0]                  kind;
	logic                        is_on;
	logic                        is_off;

	assign kind   = status_q & mngp_pkg::KIND_MASK;
	assign is_on  = (kind == mngp_pkg::KIND_NOTE_ON);
	assign is_off = (kind == mngp_pkg::KIND_NOTE_OFF);

	// a strike looks up the held first data byte
	assign rd_addr = first_q;

	// message decode for the incoming byte
	always_comb begin
		status_n = status_q;
		count_n  = count_q;
		first_n  = first_q;
		gate_n   = gate_q;
		note_n   = note_q;
		struck   = 1'b0;
		if ((rx_byte & mngp_pkg::STATUS_MASK) != 8'h00) begin
			status_n = rx_byte;
			count_n  = 1'b0;
		end else if (is_on || is_off) begin
			if (!count_q) begin
				first_n = rx_byte[mngp_pkg::NOTE_W-1:0];
				count_n = 1'b1;
			end else begin
				if (is_on && (rx_byte != 8'h00)) begin
					note_n = first_q;
					gate_n = 1'b1;
					struck = 1'b1;
				end else begin
					gate_n = 1'b0;
				end
				count_n = 1'b0;
			end
		end
	end

	// parser state and stage one item info
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			count_q  <= 1'b0;
			first_q  <= '0;
			gate_q   <= 1'b0;
			note_q   <= '0;
			info_s1  <= '0;
		end else if (accept) begin
			status_q       <= status_n;
			count_q        <= count_n;
			first_q        <= first_n;
			gate_q         <= gate_n;
			note_q         <= note_n;
			info_s1.gate   <= gate_n;
			info_s1.note   <= note_n;
			info_s1.struck <= struck;
		end
	end

endmodule
`default_nettype wire

/* rtl/midi_note_gate_pitch_parser.sv */
// MIDI note gate and pitch parser.
// midi_in carries one received MIDI byte per item; note_out returns exactly
// one item per byte: gate level, phase increment and note of the last strike,
// and a key_struck pulse for a completed Note On with nonzero velocity.
// Both channels use valid/ready; an item moves when both are high.
// A byte accepted from midi_in is registered in the decode stage (parser state
// and the registered pitch memory read), then in the output register that
// drives note_out. Throughput: one byte per cycle while note_out is not
// stalled.
// Reset clears the parser state (no running status, gate low, note 0,
// step 0). After reset the pitch memory is loaded from the constant table,
// one entry a cycle, so midi_in.ready stays low until all 128 are written.
// The memory is never written after that load, so lookups need no forwarding.
// When the receiver stalls, the output register holds its item and one more
// byte waits in the decode stage; ready drops only when both are full.
`default_nettype none
module midi_note_gate_pitch_parser (
	input wire logic   clk,
	input wire logic   arst_n,
	mngp_byte_if.sink  midi_in,
	mngp_note_if.source note_out
);

	logic [mngp_pkg::FILL_W-1:0] fill_q;
	logic                        fill_done;
	logic                        accept;
	logic                        advance;
	logic                        valid_s1;
	mngp_pkg::s1_info_t          info_s1;
	logic [mngp_pkg::NOTE_W-1:0] rd_addr;
	logic [mngp_pkg::STEP_W-1:0] rd_data;
	logic [mngp_pkg::STEP_W-1:0] step_q;
	logic [mngp_pkg::STEP_W-1:0] step_n;
	logic                        out_valid_q;

	assign fill_done = fill_q[mngp_pkg::FILL_W-1];

	// handshake and stage flow
	assign advance        = valid_s1 && (!out_valid_q || note_out.ready);
	assign midi_in.ready  = fill_done && (!valid_s1 || advance);
	assign accept         = midi_in.valid && midi_in.ready;

	// pitch table load after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (!fill_done) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	mngp_ram #(
		.WIDTH(mngp_pkg::STEP_W),
		.DEPTH(mngp_pkg::NOTES)
	) u_pitch_ram (
		.clk    (clk),
		.wr_en  (!fill_done),
		.wr_addr(fill_q[mngp_pkg::NOTE_W-1:0]),
		.wr_data(mngp_pkg::PITCH_TABLE[fill_q[mngp_pkg::NOTE_W-1:0]]),
		.rd_en  (accept),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	mngp_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.rx_byte(midi_in.rx_byte),
		.rd_addr(rd_addr),
		.info_s1(info_s1)
	);

	// decode stage occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// a strike takes the looked-up step, otherwise the last one stays
	assign step_n = info_s1.struck ? rd_data : step_q;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			step_q      <= step_n;
		end else if (note_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			note_out.gate       <= info_s1.gate;
			note_out.held_note  <= info_s1.note;
			note_out.key_struck <= info_s1.struck;
		end
	end

	assign note_out.valid      = out_valid_q;
	assign note_out.phase_step = step_q;

endmodule
`default_nettype wire

/* rtl/mngp_checker.sv */
`default_nettype none
module mngp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        gate,
	input wire logic [15:0] phase_step,
	input wire logic [6:0]  held_note,
	input wire logic        key_struck
);

	logic        seen_q;
	logic [15:0] last_step_q;
	logic [6:0]  last_note_q;

	// last delivered pitch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_step_q <= '0;
			last_note_q <= '0;
		end else if (out_valid && out_ready) begin
			seen_q      <= 1'b1;
			last_step_q <= phase_step;
			last_note_q <= held_note;
		end
	end

	// a strike always opens the gate
	a_struck_gate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_struck |-> gate)
		else $error("key_struck without gate");

	// pitch and note change only with a strike
	a_pitch_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_struck && seen_q |->
			(phase_step == last_step_q) && (held_note == last_note_q))
		else $error("pitch changed without a strike");

	// first item after reset carries reset pitch unless struck
	a_reset_pitch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_struck && !seen_q |-> (phase_step == 16'd0) && (held_note == 7'd0))
		else $error("pitch not cleared by reset");

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gate) && $stable(phase_step)
			&& $stable(held_note) && $stable(key_struck))
		else $error("stalled item changed");

endmodule

bind midi_note_gate_pitch_parser mngp_checker u_mngp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (note_out.valid),
	.out_ready (note_out.ready),
	.gate      (note_out.gate),
	.phase_step(note_out.phase_step),
	.held_note (note_out.held_note),
	.key_struck(note_out.key_struck)
);
`default_nettype wire

/* bench/midi_note_gate_pitch_parser_tb.sv */
`default_nettype none
module midi_note_gate_pitch_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_ITEMS = 1700;

	// status codes used by the stimulus
	localparam logic [7:0] KIND_POLY_PRESSURE = 8'hA0;
	localparam logic [7:0] KIND_CONTROL       = 8'hB0;
	localparam logic [7:0] KIND_PITCH_BEND    = 8'hE0;
	localparam logic [7:0] KIND_SYSTEM        = 8'hF0;
	localparam logic [7:0] SYS_TIMING_CLOCK   = 8'hF8;
	localparam logic [7:0] SYS_RESET          = 8'hFF;

	// phase increment per note, kept apart from the design's copy
	localparam logic [mngp_pkg::STEP_W-1:0] STEP_FOR_NOTE [0:mngp_pkg::NOTES-1] = '{
		16'd32,    16'd34,    16'd36,    16'd39,    16'd41,    16'd43,    16'd46,    16'd49,
		16'd52,    16'd55,    16'd58,    16'd62,    16'd65,    16'd69,    16'd73,    16'd78,
		16'd82,    16'd87,    16'd92,    16'd98,    16'd104,   16'd110,   16'd117,   16'd124,
		16'd131,   16'd139,   16'd147,   16'd156,   16'd165,   16'd175,   16'd185,   16'd197,
		16'd208,   16'd221,   16'd234,   16'd248,   16'd263,   16'd278,   16'd295,   16'd312,
		16'd331,   16'd351,   16'd371,   16'd394,   16'd417,   16'd442,   16'd468,   16'd496,
		16'd526,   16'd557,   16'd590,   16'd625,   16'd662,   16'd702,   16'd743,   16'd788,
		16'd835,   16'd884,   16'd937,   16'd993,   16'd1052,  16'd1114,  16'd1180,  16'd1251,
		16'd1325,  16'd1404,  16'd1487,  16'd1576,  16'd1670,  16'd1769,  16'd1874,  16'd1986,
		16'd2104,  16'd2229,  16'd2361,  16'd2502,  16'd2651,  16'd2808,  16'd2975,  16'd3152,
		16'd3340,  16'd3538,  16'd3749,  16'd3972,  16'd4208,  16'd4458,  16'd4723,  16'd5004,
		16'd5302,  16'd5617,  16'd5951,  16'd6305,  16'd6680,  16'd7077,  16'd7498,  16'd7944,
		16'd8417,  16'd8917,  16'd9447,  16'd10009, 16'd10604, 16'd11235, 16'd11903, 16'd12611,
		16'd13361, 16'd14155, 16'd14997, 16'd15889, 16'd16834, 16'd17835, 16'd18895, 16'd20019,
		16'd21209, 16'd22470, 16'd23807, 16'd25222, 16'd26722, 16'd28311, 16'd29995, 16'd31778,
		16'd33668, 16'd35670, 16'd37791, 16'd40038, 16'd42419, 16'd44941, 16'd47614, 16'd50445
	};

	typedef struct packed {
		logic                        gate;
		logic [mngp_pkg::STEP_W-1:0] phase_step;
		logic [mngp_pkg::NOTE_W-1:0] held_note;
		logic                        key_struck;
	} note_state_t;

	logic clk = 1'b0;
	logic arst_n;

	mngp_byte_if midi_in ();
	mngp_note_if note_out ();

	midi_note_gate_pitch_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.midi_in  (midi_in.sink),
		.note_out (note_out.source)
	);

	always #10 clk = ~clk;

	// parser state mirrored on the bench side
	logic [7:0]                  cur_status;
	logic                        have_note;
	logic [mngp_pkg::NOTE_W-1:0] pending_note;
	logic                        gate_now;
	logic [mngp_pkg::NOTE_W-1:0] struck_note;
	logic [mngp_pkg::STEP_W-1:0] struck_step;

	logic [7:0]   byte_queue [$];
	note_state_t  note_state_due [$];
	note_state_t  want_state;
	note_state_t  seen_state;
	int unsigned  bytes_total;
	int unsigned  bytes_taken;
	int unsigned  fault_count;
	int unsigned  cycle_count;

	// expected note state after one accepted byte
	function automatic void parse_midi_byte(input logic [7:0] rx);
		logic [7:0] kind;
		logic       hit;
		kind = cur_status & mngp_pkg::KIND_MASK;
		hit = 1'b0;
		if ((rx & mngp_pkg::STATUS_MASK) != 8'h00) begin
			cur_status = rx;
			have_note = 1'b0;
		end else if (kind == mngp_pkg::KIND_NOTE_ON || kind == mngp_pkg::KIND_NOTE_OFF) begin
			if (!have_note) begin
				pending_note = rx[mngp_pkg::NOTE_W-1:0];
				have_note = 1'b1;
			end else begin
				if (kind == mngp_pkg::KIND_NOTE_ON && rx != 8'h00) begin
					struck_note = pending_note;
					struck_step = STEP_FOR_NOTE[pending_note];
					gate_now = 1'b1;
					hit = 1'b1;
				end else begin
					gate_now = 1'b0;
				end
				have_note = 1'b0;
			end
		end
		note_state_due.push_back('{gate_now, struck_step, struck_note, hit});
	endfunction

	// idle share in percent for the current third of the run
	function automatic int unsigned idle_pct(input bit sender_side);
		if (bytes_taken < bytes_total / 3)
			return sender_side ? 8 : 67;
		else if (bytes_taken < 2 * bytes_total / 3)
			return sender_side ? 67 : 8;
		else
			return 0;
	endfunction

	task automatic log_fault(input string what);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch (%s): exp gate=%0b step=%0d note=%0d struck=%0b, "
				, what, want_state.gate, want_state.phase_step, want_state.held_note,
				want_state.key_struck,
				"got gate=%0b step=%0d note=%0d struck=%0b",
				seen_state.gate, seen_state.phase_step, seen_state.held_note,
				seen_state.key_struck);
	endtask

	// byte driver, predicts each item as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_in.valid <= 1'b0;
			midi_in.rx_byte <= 8'h00;
		end else begin
			if (midi_in.valid && midi_in.ready) begin
				parse_midi_byte(midi_in.rx_byte);
				bytes_taken++;
			end
			if (!midi_in.valid || midi_in.ready) begin
				if (byte_queue.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
					midi_in.valid <= 1'b1;
					midi_in.rx_byte <= byte_queue.pop_front();
				end else begin
					midi_in.valid <= 1'b0;
				end
			end
		end
	end

	// note state monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_out.ready <= 1'b0;
		end else begin
			if (note_out.valid && note_out.ready) begin
				seen_state = '{note_out.gate, note_out.phase_step, note_out.held_note,
					note_out.key_struck};
				if (note_state_due.size() == 0) begin
					want_state = '0;
					log_fault("unexpected item");
				end else begin
					want_state = note_state_due.pop_front();
					if (seen_state.gate !== want_state.gate ||
						seen_state.phase_step !== want_state.phase_step ||
						seen_state.held_note !== want_state.held_note ||
						seen_state.key_struck !== want_state.key_struck)
						log_fault("field");
				end
			end
			note_out.ready <= ($urandom_range(99) >= idle_pct(1'b0));
		end
	end

	// run time guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned pick;
		int unsigned extra;
		logic [3:0]  chan;

		arst_n = 1'b0;
		cur_status = 8'h00;
		have_note = 1'b0;
		pending_note = '0;
		gate_now = 1'b0;
		struck_note = '0;
		struck_step = '0;
		bytes_taken = 0;
		fault_count = 0;

		// directed: data before status, table ends, running status,
		// zero velocity, note off with another note, status mid-message,
		// other message kinds
		byte_queue = '{
			8'h00, 8'h7F,
			mngp_pkg::KIND_NOTE_ON, 8'h00, 8'h7F,
			8'h7F, 8'h01,
			8'h45, 8'h00,
			8'h60, 8'h40,
			mngp_pkg::KIND_NOTE_OFF | 8'h0F, 8'h10, 8'h00,
			mngp_pkg::KIND_NOTE_ON | 8'h0F, 8'h30, SYS_TIMING_CLOCK, 8'h40,
			mngp_pkg::KIND_NOTE_OFF, 8'h12, mngp_pkg::KIND_NOTE_ON | 8'h05, 8'h22, 8'h33,
			KIND_POLY_PRESSURE, 8'h10, 8'h20,
			SYS_RESET, 8'h55
		};

		// random: mostly well-formed note messages, plus noise
		while (byte_queue.size() < RANDOM_ITEMS) begin
			pick = $urandom_range(99);
			chan = 4'($urandom_range(15));
			if (pick < 60) begin
				if ($urandom_range(2) != 0)
					byte_queue.push_back(($urandom_range(1) ? mngp_pkg::KIND_NOTE_ON
						: mngp_pkg::KIND_NOTE_OFF) | {4'h0, chan});
				byte_queue.push_back({1'b0, 7'($urandom_range(127))});
				if ($urandom_range(4) == 0)
					byte_queue.push_back(8'h00);
				else
					byte_queue.push_back({1'b0, 7'($urandom_range(127))});
			end else if (pick < 70) begin
				// message cut short by a new status
				byte_queue.push_back({1'b0, 7'($urandom_range(127))});
				byte_queue.push_back(8'($urandom_range(255, 128)));
			end else if (pick < 78) begin
				byte_queue.push_back(SYS_TIMING_CLOCK | 8'($urandom_range(7)));
			end else if (pick < 88) begin
				// other voice or system message with its data
				case ($urandom_range(3))
					0: byte_queue.push_back(KIND_POLY_PRESSURE | {4'h0, chan});
					1: byte_queue.push_back(KIND_CONTROL | {4'h0, chan});
					2: byte_queue.push_back(KIND_PITCH_BEND | {4'h0, chan});
					default: byte_queue.push_back(KIND_SYSTEM | {4'h0, chan});
				endcase
				extra = $urandom_range(2, 1);
				repeat (extra) byte_queue.push_back({1'b0, 7'($urandom_range(127))});
			end else begin
				byte_queue.push_back(8'($urandom_range(255)));
			end
		end
		bytes_total = byte_queue.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// wait until every byte is taken and every item is checked
		while (bytes_taken < bytes_total || note_state_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire
